[src/ldcc_pkg.sv]
// Shared types, register codes and constants for the light driven chirp controller.
// No dependencies; all but the two interfaces use this package by scoped names.
`timescale 1ns / 1ps

package ldcc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHADY_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEADY_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_BASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_HOLD   = 3'd6;

    // Register reset values
    localparam logic [7:0]  RST_BRIGHT_LEVEL = 8'd192;
    localparam logic [7:0]  RST_SHADY_LEVEL  = 8'd128;
    localparam logic [7:0]  RST_DARK_LEVEL   = 8'd64;
    localparam logic [11:0] RST_STEADY_LIMIT = 12'd2400;
    localparam logic [7:0]  RST_BASE_PERIOD  = 8'd180;
    localparam logic [9:0]  RST_PITCH_BASE   = 10'd800;
    localparam logic [4:0]  RST_QUIET_HOLD   = 5'd20;

    // Light classes
    localparam logic [2:0] CLS_START  = 3'd0;
    localparam logic [2:0] CLS_TOO    = 3'd1;
    localparam logic [2:0] CLS_BRIGHT = 3'd2;
    localparam logic [2:0] CLS_SHADY  = 3'd3;
    localparam logic [2:0] CLS_DARK   = 3'd4;

    // Arithmetic constants
    localparam logic [4:0] HOLD_ACT_LIMIT  = 5'd10;
    localparam logic [4:0] HOLD_SHIFT_MAX  = 5'd4;
    localparam logic [5:0] DUTY_BRIGHT_ADD = 6'd32;
    localparam logic [5:0] DUTY_SHADY_ADD  = 6'd10;
    localparam logic [9:0] PERIOD_OFFSET   = 10'd128;
    localparam logic [7:0] PITCH_OFFSET    = 8'd255;
    localparam logic [9:0] PITCH_MAX       = 10'd639;

    typedef struct packed {
        logic [7:0]  bright_level;
        logic [7:0]  shady_level;
        logic [7:0]  dark_level;
        logic [11:0] steady_limit;
        logic [7:0]  base_period;
        logic [9:0]  pitch_base;
        logic [4:0]  quiet_hold;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  cls;
        logic        sleeping;
        logic [11:0] countdown;
        logic [4:0]  hold_off;
        logic [5:0]  duty;
        logic [5:0]  duty_cnt;
        logic        tone_en;
        logic        drive_en;
        logic [8:0]  period;
        logic [9:0]  pitch;
    } t_state;

endpackage

[src/ldcc_in_if.sv]
// Input channel of the chirp controller: valid/ready handshake with func and light level.
// Depends on nothing.
`timescale 1ns / 1ps

interface ldcc_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] light_level;

    modport source (output valid, output func, output light_level, input ready);
    modport sink   (input valid, input func, input light_level, output ready);
endinterface

[src/ldcc_out_if.sv]
// Result channel of the chirp controller: valid/ready handshake with the state after each item.
// Depends on nothing.
`timescale 1ns / 1ps

interface ldcc_out_if;
    logic       valid;
    logic       ready;
    logic       tone_on;
    logic       drive_on;
    logic [8:0] chirp_period;
    logic [9:0] tone_pitch;
    logic [2:0] light_class;
    logic       asleep;

    modport source (output valid, output tone_on, output drive_on, output chirp_period,
                    output tone_pitch, output light_class, output asleep, input ready);
    modport sink   (input valid, input tone_on, input drive_on, input chirp_period,
                    input tone_pitch, input light_class, input asleep, output ready);
endinterface

[src/ldcc_cfg_regs.sv]
// Configuration register file: seven threshold and base registers behind a plain write port.
// Depends on ldcc_pkg.
`timescale 1ns / 1ps

module ldcc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ldcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ldcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ldcc_pkg::t_cfg                   o_cfg
);

    ldcc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bright_level <= ldcc_pkg::RST_BRIGHT_LEVEL;
            r_cfg.shady_level  <= ldcc_pkg::RST_SHADY_LEVEL;
            r_cfg.dark_level   <= ldcc_pkg::RST_DARK_LEVEL;
            r_cfg.steady_limit <= ldcc_pkg::RST_STEADY_LIMIT;
            r_cfg.base_period  <= ldcc_pkg::RST_BASE_PERIOD;
            r_cfg.pitch_base   <= ldcc_pkg::RST_PITCH_BASE;
            r_cfg.quiet_hold   <= ldcc_pkg::RST_QUIET_HOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ldcc_pkg::REG_BRIGHT_LEVEL: r_cfg.bright_level <= i_cfg_data[7:0];
                ldcc_pkg::REG_SHADY_LEVEL:  r_cfg.shady_level  <= i_cfg_data[7:0];
                ldcc_pkg::REG_DARK_LEVEL:   r_cfg.dark_level   <= i_cfg_data[7:0];
                ldcc_pkg::REG_STEADY_LIMIT: r_cfg.steady_limit <= i_cfg_data[11:0];
                ldcc_pkg::REG_BASE_PERIOD:  r_cfg.base_period  <= i_cfg_data[7:0];
                ldcc_pkg::REG_PITCH_BASE:   r_cfg.pitch_base   <= i_cfg_data[9:0];
                ldcc_pkg::REG_QUIET_HOLD:   r_cfg.quiet_hold   <= i_cfg_data[4:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/ldcc_step.sv]
// Next-state logic for one item: light classification, duty/period/pitch update, sleep
// tracking and duty-tick gating. Purely combinational; depends on ldcc_pkg.
`timescale 1ns / 1ps

module ldcc_step (
    input  ldcc_pkg::t_cfg   i_cfg,
    input  ldcc_pkg::t_state i_state,
    input  logic             i_func,
    input  logic [7:0]       i_light,
    output ldcc_pkg::t_state o_state
);

    logic [2:0]  w_cls;
    logic [9:0]  w_per_sum;
    logic [10:0] w_pitch_sum;
    logic [3:0]  w_duty_shr;

    always_comb begin
        priority if (i_light > i_cfg.bright_level) w_cls = ldcc_pkg::CLS_TOO;
        else if (i_light > i_cfg.shady_level)      w_cls = ldcc_pkg::CLS_BRIGHT;
        else if (i_light > i_cfg.dark_level)       w_cls = ldcc_pkg::CLS_SHADY;
        else                                       w_cls = ldcc_pkg::CLS_DARK;
    end

    assign w_per_sum   = {2'b00, i_cfg.base_period} + {2'b00, i_light};
    assign w_pitch_sum = {1'b0, i_cfg.pitch_base}
                       + {3'b000, ldcc_pkg::PITCH_OFFSET - i_light};
    // light >> (4 + hold); only hold below 4 leaves anything
    assign w_duty_shr  = i_light[7:4] >> i_state.hold_off[1:0];

    always_comb begin
        o_state = i_state;
        if (!i_func) begin
            if (!i_state.sleeping) begin
                if (i_state.hold_off < ldcc_pkg::HOLD_SHIFT_MAX) begin
                    o_state.duty = {2'b00, w_duty_shr};
                end else begin
                    o_state.duty = '0;
                end
                if (i_state.hold_off < ldcc_pkg::HOLD_ACT_LIMIT) begin
                    priority if (w_cls == ldcc_pkg::CLS_BRIGHT) begin
                        // base - 128 + light, clamped at zero, then >> 2
                        if (w_per_sum < ldcc_pkg::PERIOD_OFFSET) begin
                            o_state.period = '0;
                        end else begin
                            o_state.period =
                                {2'b00, 7'((w_per_sum - ldcc_pkg::PERIOD_OFFSET) >> 2)};
                        end
                        o_state.duty     = o_state.duty + ldcc_pkg::DUTY_BRIGHT_ADD;
                        o_state.tone_en  = 1'b1;
                        o_state.drive_en = 1'b1;
                    end else if (w_cls == ldcc_pkg::CLS_SHADY
                                 || w_cls == ldcc_pkg::CLS_DARK) begin
                        if (w_cls == ldcc_pkg::CLS_SHADY) begin
                            o_state.duty = o_state.duty + ldcc_pkg::DUTY_SHADY_ADD;
                        end
                        o_state.tone_en  = 1'b1;
                        o_state.drive_en = 1'b1;
                        o_state.period   = w_per_sum[8:0];
                    end else begin
                        o_state.duty     = '0;
                        o_state.tone_en  = 1'b0;
                        o_state.drive_en = 1'b0;
                        o_state.hold_off = i_cfg.quiet_hold;
                    end
                end
            end

            if (o_state.hold_off != '0) begin
                o_state.hold_off = o_state.hold_off - 5'd1;
            end

            o_state.pitch = w_pitch_sum[10:1];

            if (w_cls != i_state.cls) begin
                o_state.sleeping  = 1'b0;
                o_state.countdown = i_cfg.steady_limit;
                o_state.cls       = w_cls;
            end else if (!i_state.sleeping) begin
                if (i_state.countdown == '0) begin
                    o_state.sleeping = 1'b1;
                    o_state.duty     = '0;
                    o_state.tone_en  = 1'b0;
                end else begin
                    o_state.countdown = i_state.countdown - 12'd1;
                end
            end
        end else begin
            // duty tick: tone off while duty is zero or hold-off runs, else on once every duty+1 ticks
            priority if (i_state.duty == '0 || i_state.hold_off != '0) begin
                o_state.tone_en = 1'b0;
            end else if (i_state.duty_cnt < i_state.duty) begin
                o_state.tone_en  = 1'b0;
                o_state.duty_cnt = i_state.duty_cnt + 6'd1;
            end else begin
                o_state.tone_en  = 1'b1;
                o_state.duty_cnt = '0;
            end
        end
    end

endmodule

[src/light_driven_chirp_controller.sv]
// Light driven chirp controller top level: input register, next-state step, result register.
// Depends on ldcc_pkg, ldcc_in_if, ldcc_out_if, ldcc_cfg_regs and ldcc_step.
//
// Usage:
//   i_in carries items: func 0 is a light sample (light_level used), func 1 is a
//   duty tick. Each item gives exactly one result on o_out: tone and drive enables,
//   chirp period, tone pitch, light class and sleep flag as they stand after it.
//   Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data, one register per
//   cycle, and is meant to be written while no item is in flight.
//   Path: an accepted item passes the input register, then the result register,
//   and a held result can keep it waiting in the input register.
//   Throughput: one item per cycle while o_out takes each result, as the state
//   update between the input register and the result register is combinational.
//   Reset (i_rst_n low, synchronous) loads register defaults and the power-on
//   state, and empties both stages.
//   When o_out.ready is low the result holds; one more item may sit in the input
//   register, after which i_in.ready drops until the result is taken.
`timescale 1ns / 1ps

module light_driven_chirp_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ldcc_in_if.sink                         i_in,
    ldcc_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [ldcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ldcc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ldcc_pkg::t_cfg   w_cfg;
    ldcc_pkg::t_state r_state;
    ldcc_pkg::t_state n_state;

    logic       r_in_valid;
    logic       r_func;
    logic [7:0] r_light;
    logic       r_out_valid;
    logic       w_adv;

    ldcc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ldcc_step u_step (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_func  (r_func),
        .i_light (r_light),
        .o_state (n_state)
    );

    // item moves from the input register into state and result register
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_func  <= i_in.func;
            r_light <= i_in.light_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cls       <= ldcc_pkg::CLS_START;
            r_state.sleeping  <= 1'b0;
            r_state.countdown <= ldcc_pkg::RST_STEADY_LIMIT;
            r_state.hold_off  <= '0;
            r_state.duty      <= '0;
            r_state.duty_cnt  <= '0;
            r_state.tone_en   <= 1'b1;
            r_state.drive_en  <= 1'b1;
            r_state.period    <= {1'b0, ldcc_pkg::RST_BASE_PERIOD};
            r_state.pitch     <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result register mirrors the state written by the same item
    assign o_out.valid        = r_out_valid;
    assign o_out.tone_on      = r_state.tone_en;
    assign o_out.drive_on     = r_state.drive_en;
    assign o_out.chirp_period = r_state.period;
    assign o_out.tone_pitch   = r_state.pitch;
    assign o_out.light_class  = r_state.cls;
    assign o_out.asleep       = r_state.sleeping;

    a_sleep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.sleeping |-> (r_state.duty == '0 && !r_state.tone_en))
        else $error("asleep with nonzero duty or tone enabled");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("state changed without an item");

    a_class_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.cls != ldcc_pkg::CLS_START) |=> (r_state.cls != ldcc_pkg::CLS_START))
        else $error("light class returned to startup");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state.pitch <= ldcc_pkg::PITCH_MAX))
        else $error("pitch out of range");

endmodule

[dv/testbench.sv]
// Self-checking bench for light_driven_chirp_controller: queued light samples and duty ticks,
// a per-item predictor of the chirp state, per-field compare of every result.
// Depends on ldcc_pkg, ldcc_in_if, ldcc_out_if and the controller RTL.
`timescale 1ns / 1ps

module testbench;

    localparam logic [ldcc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam int LATENCY       = 2;
    localparam int LONG_HOLD     = 300;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 125;

    typedef struct {
        logic       func;
        logic [7:0] light;
    } t_chirp_item;

    typedef struct {
        logic       tone;
        logic       drive;
        logic [8:0] period;
        logic [9:0] pitch;
        logic [2:0] cls;
        logic       asleep;
    } t_chirp_res;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [ldcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ldcc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ldcc_in_if  in_ch();
    ldcc_out_if out_ch();

    light_driven_chirp_controller uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_chirp_item pending_items[$];
    t_chirp_res  expected_results[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;
    int   errors        = 0;
    int   cycles        = 0;
    logic in_fire       = 1'b0;

    // predicted controller state and its register copy
    ldcc_pkg::t_cfg cfg;
    logic [2:0] lit_class;
    logic       dozing;
    logic [11:0] steady_left;
    logic [4:0] quiet_left;
    logic [5:0] duty;
    logic [5:0] duty_cnt;
    logic       tone_en;
    logic       drive_en;
    logic [8:0] period;
    logic [9:0] pitch;

    function automatic logic [2:0] classify(logic [7:0] light);
        if (light > cfg.bright_level) return ldcc_pkg::CLS_TOO;
        else if (light > cfg.shady_level) return ldcc_pkg::CLS_BRIGHT;
        else if (light > cfg.dark_level) return ldcc_pkg::CLS_SHADY;
        return ldcc_pkg::CLS_DARK;
    endfunction

    function automatic t_chirp_res advance_controller(t_chirp_item it);
        t_chirp_res r;
        logic [2:0] c;
        int         lvl;
        int         sh;
        int         acc;
        int         sum;
        lvl = it.light;
        if (it.func == FUNC_SAMPLE) begin
            c = classify(it.light);
            if (!dozing) begin
                sh = 4 + quiet_left;
                acc = (sh < 8) ? (lvl >> sh) : 0;
                if (quiet_left < ldcc_pkg::HOLD_ACT_LIMIT) begin
                    if (c == ldcc_pkg::CLS_BRIGHT) begin
                        // can go negative when base_period plus light sits below the offset
                        sum = int'(cfg.base_period) - int'(ldcc_pkg::PERIOD_OFFSET) + lvl;
                        if (sum < 0) sum = 0;
                        period = 9'(sum >> 2);
                        acc += ldcc_pkg::DUTY_BRIGHT_ADD;
                        tone_en = 1'b1;
                        drive_en = 1'b1;
                    end else if (c == ldcc_pkg::CLS_SHADY || c == ldcc_pkg::CLS_DARK) begin
                        if (c == ldcc_pkg::CLS_SHADY) acc += ldcc_pkg::DUTY_SHADY_ADD;
                        tone_en = 1'b1;
                        drive_en = 1'b1;
                        period = 9'(int'(cfg.base_period) + lvl);
                    end else begin
                        acc = 0;
                        tone_en = 1'b0;
                        drive_en = 1'b0;
                        quiet_left = cfg.quiet_hold;
                    end
                end
                duty = 6'(acc);
            end
            if (quiet_left != 0) quiet_left = quiet_left - 5'd1;
            pitch = 10'((int'(cfg.pitch_base) + int'(ldcc_pkg::PITCH_OFFSET) - lvl) >> 1);
            if (c != lit_class) begin
                dozing = 1'b0;
                steady_left = cfg.steady_limit;
                lit_class = c;
            end else if (!dozing) begin
                if (steady_left == 0) begin
                    dozing = 1'b1;
                    duty = '0;
                    tone_en = 1'b0;
                end else begin
                    steady_left = steady_left - 12'd1;
                end
            end
        end else begin
            if (duty == 0 || quiet_left != 0) begin
                tone_en = 1'b0;
            end else if (duty_cnt < duty) begin
                tone_en = 1'b0;
                duty_cnt = duty_cnt + 6'd1;
            end else begin
                tone_en = 1'b1;
                duty_cnt = '0;
            end
        end
        r.tone   = tone_en;
        r.drive  = drive_en;
        r.period = period;
        r.pitch  = pitch;
        r.cls    = lit_class;
        r.asleep = dozing;
        return r;
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // driver: a new item goes out only once the previous one was taken
    always @(negedge i_clk) begin
        t_chirp_item nxt;
        if (!in_ch.valid || in_fire) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_items.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.func        <= nxt.func;
                in_ch.light_level <= nxt.light;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result side backpressure, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served  <= hold_requests;
            hold_left    <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: check results first, then predict for the item taken at this edge
    always @(posedge i_clk) begin
        t_chirp_res  want;
        t_chirp_item taken;
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, got class %0d",
                         $time, out_ch.light_class);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("tone_on", want.tone, out_ch.tone_on);
                check_field("drive_on", want.drive, out_ch.drive_on);
                check_field("chirp_period", want.period, out_ch.chirp_period);
                check_field("tone_pitch", want.pitch, out_ch.tone_pitch);
                check_field("light_class", want.cls, out_ch.light_class);
                check_field("asleep", want.asleep, out_ch.asleep);
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            taken.func  = in_ch.func;
            taken.light = in_ch.light_level;
            expected_results.push_back(advance_controller(taken));
        end
    end

    task automatic write_reg(logic [ldcc_pkg::CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= ldcc_pkg::CFG_DATA_W'(val);
        case (idx)
            ldcc_pkg::REG_BRIGHT_LEVEL: cfg.bright_level = 8'(val);
            ldcc_pkg::REG_SHADY_LEVEL:  cfg.shady_level  = 8'(val);
            ldcc_pkg::REG_DARK_LEVEL:   cfg.dark_level   = 8'(val);
            ldcc_pkg::REG_STEADY_LIMIT: cfg.steady_limit = 12'(val);
            ldcc_pkg::REG_BASE_PERIOD:  cfg.base_period  = 8'(val);
            ldcc_pkg::REG_PITCH_BASE:   cfg.pitch_base   = 10'(val);
            ldcc_pkg::REG_QUIET_HOLD:   cfg.quiet_hold   = 5'(val);
            default: ;
        endcase
    endtask

    task automatic apply_cfg(int bright, int shady, int dark, int sleep_n,
                             int base_per, int base_pit, int hold);
        write_reg(REG_UNUSED, $urandom_range(4095));
        write_reg(ldcc_pkg::REG_BRIGHT_LEVEL, bright);
        write_reg(ldcc_pkg::REG_SHADY_LEVEL, shady);
        write_reg(ldcc_pkg::REG_DARK_LEVEL, dark);
        write_reg(ldcc_pkg::REG_STEADY_LIMIT, sleep_n);
        write_reg(ldcc_pkg::REG_BASE_PERIOD, base_per);
        write_reg(ldcc_pkg::REG_PITCH_BASE, base_pit);
        write_reg(ldcc_pkg::REG_QUIET_HOLD, hold);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_sample(int light);
        t_chirp_item it;
        it.func  = FUNC_SAMPLE;
        it.light = 8'(light);
        pending_items.push_back(it);
    endtask

    task automatic add_tick();
        t_chirp_item it;
        it.func  = FUNC_TICK;
        it.light = 8'($urandom_range(255));
        pending_items.push_back(it);
    endtask

    // light level that lands in the wanted class if one is found, tried around the thresholds too; else any level
    function automatic int pick_light(logic [2:0] target);
        int l;
        for (int k = 0; k < 24; k++) begin
            case ($urandom_range(4))
                0: l = cfg.bright_level + $urandom_range(1);
                1: l = cfg.shady_level + $urandom_range(1);
                2: l = cfg.dark_level + $urandom_range(1);
                default: l = $urandom_range(255);
            endcase
            l = l & 8'hFF;
            if (classify(8'(l)) == target) return l;
        end
        return $urandom_range(255);
    endfunction

    // mostly steady runs of one class (long enough to doze off when the steady limit is small), some noise
    task automatic random_items(int count);
        int         done;
        int         run_len;
        logic [2:0] target;
        done = 0;
        while (done < count) begin
            if ($urandom_range(99) < 85) begin
                target  = 3'($urandom_range(ldcc_pkg::CLS_DARK, ldcc_pkg::CLS_TOO));
                run_len = (cfg.steady_limit < 20) ? $urandom_range(1, cfg.steady_limit + 5)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < run_len && done < count; k++) begin
                    if ($urandom_range(99) < 30) add_tick();
                    else add_sample(pick_light(target));
                    done++;
                end
            end else begin
                if ($urandom_range(1)) add_tick();
                else add_sample($urandom_range(255));
                done++;
            end
        end
    endtask

    // checked at the rising edge, where the driven item and the queue are settled
    task automatic wait_drained();
        forever begin
            @(posedge i_clk);
            if (pending_items.size() == 0 && !in_ch.valid && expected_results.size() == 0)
                break;
        end
    endtask

    initial begin
        int t0, t1, t2, tmp;
        int sleep_n, base_per;
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_SAMPLE;
        in_ch.light_level = '0;
        out_ch.ready      = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        i_rst_n           = 1'b0;

        cfg.bright_level = ldcc_pkg::RST_BRIGHT_LEVEL;
        cfg.shady_level  = ldcc_pkg::RST_SHADY_LEVEL;
        cfg.dark_level   = ldcc_pkg::RST_DARK_LEVEL;
        cfg.steady_limit = ldcc_pkg::RST_STEADY_LIMIT;
        cfg.base_period  = ldcc_pkg::RST_BASE_PERIOD;
        cfg.pitch_base   = ldcc_pkg::RST_PITCH_BASE;
        cfg.quiet_hold   = ldcc_pkg::RST_QUIET_HOLD;
        lit_class   = ldcc_pkg::CLS_START;
        dozing      = 1'b0;
        steady_left = ldcc_pkg::RST_STEADY_LIMIT;
        quiet_left  = '0;
        duty        = '0;
        duty_cnt    = '0;
        tone_en     = 1'b1;
        drive_en    = 1'b1;
        period      = 9'(ldcc_pkg::RST_BASE_PERIOD);
        pitch       = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 87;

        // reset settings: threshold edges, ticks, then too bright with a long hold-off
        add_sample(0);
        add_sample(64);
        add_sample(65);
        add_sample(128);
        add_sample(129);
        add_sample(192);
        add_tick();
        add_tick();
        add_tick();
        add_sample(193);
        add_tick();
        add_sample(255);
        wait_drained();

        // low base period clamps, doze off on the first repeat, wake on a new class
        apply_cfg(192, 10, 5, 0, 0, 1023, 12);
        add_sample(50);
        add_sample(50);
        add_tick();
        add_sample(60);
        add_sample(3);
        add_sample(255);
        add_sample(200);
        add_sample(150);
        add_sample(150);
        add_tick();
        add_sample(7);
        add_sample(0);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 4) begin
                send_idle_pct = 87;
                recv_idle_pct = 26;
            end else if (ph == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: apply_cfg(0, 0, 0, 0, 0, 0, 0);
                1: apply_cfg(255, 255, 255, 4095, 255, 1023, 31);
                2: apply_cfg(10, 200, 255, 3, 128, 512, 5);
                default: begin
                    t0 = $urandom_range(255);
                    t1 = $urandom_range(255);
                    t2 = $urandom_range(255);
                    if ($urandom_range(99) < 80) begin
                        if (t0 < t1) begin tmp = t0; t0 = t1; t1 = tmp; end
                        if (t1 < t2) begin tmp = t1; t1 = t2; t2 = tmp; end
                        if (t0 < t1) begin tmp = t0; t0 = t1; t1 = tmp; end
                    end
                    sleep_n  = ($urandom_range(99) < 80) ? $urandom_range(15)
                                                         : $urandom_range(4095);
                    base_per = ($urandom_range(99) < 80) ? $urandom_range(128, 255)
                                                         : $urandom_range(127);
                    apply_cfg(t0, t1, t2, sleep_n, base_per, $urandom_range(1023),
                              $urandom_range(31));
                end
            endcase
            random_items(PHASE_ITEMS);
            // sender keeps offering while the result side sits on its hands
            if (ph == 9) hold_requests++;
            wait_drained();
        end

        repeat (LATENCY * 4) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
